// ===== rtl/aes_pkg.sv =====
package aes_pkg;

    typedef logic [31:0] t_word;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_SIZE = 3'd0,
        REG_KEY_0    = 3'd1,
        REG_KEY_1    = 3'd2,
        REG_KEY_2    = 3'd3,
        REG_KEY_3    = 3'd4
    } t_reg_idx;

    // What a round stage does with the item passing through it
    typedef enum logic [1:0] {
        RM_FULL,
        RM_LAST,
        RM_PASS
    } t_rmode;

    localparam int RK_WORDS   = 60;
    localparam int MAX_ROUNDS = 14;

    localparam logic [0:255][7:0] SBOX = {
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic t_word sbox_word(input t_word w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Key words: 128/192/256 bit keys give 4, 6 or 8; code 3 counts as 256
    function automatic logic [3:0] key_words(input logic [1:0] ks);
        logic [3:0] nk;
        case (ks)
            2'd0:    nk = 4'd4;
            2'd1:    nk = 4'd6;
            default: nk = 4'd8;
        endcase
        return nk;
    endfunction

    // Byte n of the state sits at bits [127-8n -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] =
                    sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

endpackage

// ===== rtl/aes_kexp.sv =====
module aes_kexp import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_key_size,
    input  logic [63:0] i_key [4],
    output logic        o_busy,
    output t_word       o_rk [RK_WORDS]
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [2:0]  r_j;
    logic [7:0]  r_rcon;
    t_word       r_win [8];
    t_word       r_rk [RK_WORDS];

    logic [3:0]  nk;
    t_word       key_word;
    t_word       far_word;
    t_word       t;
    t_word       n_word;
    logic        use_key;
    logic        rcon_step;

    assign nk      = key_words(i_key_size);
    assign use_key = ({1'b0, r_cnt} < {3'd0, nk});

    // Pick the key word straight from the key registers
    always_comb begin
        if (r_cnt[0]) begin
            key_word = i_key[r_cnt[2:1]][31:0];
        end else begin
            key_word = i_key[r_cnt[2:1]][63:32];
        end
    end

    // Word i-nk from the sliding window
    always_comb begin
        case (nk)
            4'd4:    far_word = r_win[3];
            4'd6:    far_word = r_win[5];
            default: far_word = r_win[7];
        endcase
    end

    // Schedule step: RotWord/SubWord/Rcon, or SubWord alone for 256 bit keys
    always_comb begin
        rcon_step = 1'b0;
        t         = r_win[0];
        if (r_j == 3'd0) begin
            rcon_step = !use_key;
            t = sbox_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'd0};
        end else if (nk == 4'd8 && r_j == 3'd4) begin
            t = sbox_word(r_win[0]);
        end
        n_word = use_key ? key_word : (far_word ^ t);
    end

    // Sequence control: restart on reset or any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_j    <= '0;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 6'd1;
            r_busy <= (r_cnt != 6'(RK_WORDS - 1));
            r_j    <= ({1'b0, r_j} == nk - 4'd1) ? 3'd0 : r_j + 3'd1;
            if (rcon_step) begin
                r_rcon <= xtime(r_rcon);
            end
        end
    end

    // Store each new word and advance the window
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rk[r_cnt] <= n_word;
            r_win[0]    <= n_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k - 1];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rk   = r_rk;

endmodule

// ===== rtl/aes_rnd.sv =====
module aes_rnd import aes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_rmode       i_mode,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    output logic         o_valid,
    output logic [127:0] o_state
);

    logic         r_valid;
    logic [127:0] r_state;
    logic [127:0] ss;
    logic [127:0] n_state;

    assign ss = sub_shift(i_state);

    // One cipher round, the final round, or pass through past the last round
    always_comb begin
        case (i_mode)
            RM_FULL: n_state = mix_columns(ss) ^ i_key;
            RM_LAST: n_state = ss ^ i_key;
            default: n_state = i_state;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

// ===== rtl/aes_block_encrypt.sv =====
// Channel   | valid    | stall    | payload
// input     | i_valid  | o_stall  | i_block_hi, i_block_lo
// output    | o_valid  | i_stall  | o_cipher_hi, o_cipher_lo
// config    | i_wr_en  | -        | i_wr_idx, i_wr_data
//
// One item per cycle while o_stall is low; the first key add is registered,
// then one register per round for all 14 round stages; shorter keys pass through.
// After reset and after every register write the key schedule runs one word
// a cycle through all 60 round key words; o_stall is high meanwhile.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module aes_block_encrypt import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_cipher_hi,
    output logic [63:0] o_cipher_lo,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_idx,
    input  logic [63:0] i_wr_data
);

    logic [1:0]   r_key_size;
    logic [63:0]  r_key [4];
    logic         r_v0;
    logic [127:0] r_s0;

    logic         kx_busy;
    t_word        rk [RK_WORDS];
    logic         en;
    logic         in_acc;
    logic [3:0]   nr;
    logic [MAX_ROUNDS:0] v;
    logic [127:0] st [MAX_ROUNDS + 1];

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= '0;
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_wr_en) begin
            case (t_reg_idx'(i_wr_idx))
                REG_KEY_SIZE: r_key_size <= i_wr_data[1:0];
                REG_KEY_0:    r_key[0]   <= i_wr_data;
                REG_KEY_1:    r_key[1]   <= i_wr_data;
                REG_KEY_2:    r_key[2]   <= i_wr_data;
                REG_KEY_3:    r_key[3]   <= i_wr_data;
                default:      ;
            endcase
        end
    end

    aes_kexp u_kexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_wr_en),
        .i_key_size (r_key_size),
        .i_key      (r_key),
        .o_busy     (kx_busy),
        .o_rk       (rk)
    );

    // Advance everything unless a result waits on a stalled output
    assign en      = !(v[MAX_ROUNDS] && i_stall);
    assign o_stall = !en || kx_busy;
    assign in_acc  = i_valid && !o_stall;
    assign nr      = key_words(r_key_size) + 4'd6;

    // Initial key add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= {i_block_hi, i_block_lo} ^ {rk[0], rk[1], rk[2], rk[3]};
        end
    end

    assign v[0]  = r_v0;
    assign st[0] = r_s0;

    for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_round
        t_rmode mode;
        always_comb begin
            if (4'(r) < nr) begin
                mode = RM_FULL;
            end else if (4'(r) == nr) begin
                mode = RM_LAST;
            end else begin
                mode = RM_PASS;
            end
        end

        aes_rnd u_rnd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[r - 1]),
            .i_mode  (mode),
            .i_state (st[r - 1]),
            .i_key   ({rk[4 * r], rk[4 * r + 1], rk[4 * r + 2], rk[4 * r + 3]}),
            .o_valid (v[r]),
            .o_state (st[r])
        );
    end

    assign o_valid     = v[MAX_ROUNDS];
    assign o_cipher_hi = st[MAX_ROUNDS][127:64];
    assign o_cipher_lo = st[MAX_ROUNDS][63:0];

    // An accepted item lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_v0)
        else $error("accepted item missing from first stage");

    // A register write restarts the key schedule
    a_kx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> kx_busy)
        else $error("key schedule did not restart");

    // A waiting result moves along one stage only when the pipeline advances
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[MAX_ROUNDS - 1] && !en) |=> v[MAX_ROUNDS - 1])
        else $error("item lost while pipeline frozen");

endmodule
